FILE: rtl/core/rotor_effectiveness_column_unit_assert.svh
// Assertion helpers for the rotor effectiveness column unit.
// Each use names clk and rst_n of the including module.
`ifndef ROTOR_EFFECTIVENESS_COLUMN_UNIT_ASSERT_SVH
`define ROTOR_EFFECTIVENESS_COLUMN_UNIT_ASSERT_SVH

// Property checked at every edge outside reset.
`define REC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rec: assertion failed");

// Condition that must hold whenever a result is strobed.
`define REC_ASSERT_ON_STROBE(lbl, strobe, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (strobe) |-> (cond)) \
    else $error("rec: result check failed");

`endif

FILE: rtl/core/rec_pkg.sv
package rec_pkg;

  localparam int MAX_ROTORS_DEF    = 12;
  localparam int MAX_ACTUATORS_DEF = 16;

  localparam int NORM_FRAC    = 44;
  localparam int THRUST_SHIFT = 23;
  localparam int MOMENT_SHIFT = 37;

  typedef enum logic [2:0] {
    CFG_ACT_START       = 3'd0,
    CFG_TORQUE_OFF      = 3'd1,
    CFG_TORQUE_OFF_NUP  = 3'd2,
    CFG_YAW_ROW_OFF     = 3'd3,
    CFG_THRUST_SCALAR   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]         rotor_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] ct_coeff;
    logic signed [15:0] km_ratio;
    logic               last_rotor;
  } rec_in_t;

  typedef struct packed {
    logic [4:0]         column;
    logic               in_range;
    logic               write_column;
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last_out;
  } rec_out_t;

endpackage

FILE: rtl/core/rotor_effectiveness_column_unit.sv
// Stages: 1, 2, root, divide seed, divide, sign, products, sums, rounding, output.
// Throughput: one rotor per cycle; busy is never raised, the pipe has no stall.
// The depth is set by the 32-step square root and the 29-step normalising divide,
// each retiring two steps per stage.
// Reset (rst_n low, synchronous) clears the config registers and all stage valid bits.
module rotor_effectiveness_column_unit #(
  parameter int MAX_ROTORS    = rec_pkg::MAX_ROTORS_DEF,
  parameter int MAX_ACTUATORS = rec_pkg::MAX_ACTUATORS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // item channel
  input  logic             start,
  output logic             busy,
  input  rec_pkg::rec_in_t in_item,
  // result channel
  output logic             out_strobe,
  output rec_pkg::rec_out_t out_data,
  // config write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  // Square root: 32 result bits, two per stage.
  localparam int SQ_BITS   = 32;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = SQ_BITS / SQ_STEPS;
  // Normalising divide: quotient never exceeds 2^28, so 29 bits.
  localparam int DV_BITS   = 29;
  localparam int DV_STEPS  = 2;
  localparam int DV_STAGES = (DV_BITS + DV_STEPS - 1) / DV_STEPS;
  localparam int LATENCY   = SQ_STAGES + DV_STAGES + 8;

  // Side data that rides with each item.
  typedef struct packed {
    logic                valid;
    logic [4:0]          column;
    logic                in_range;
    logic                wr;
    logic                last;
    logic signed [15:0]  ct;
    logic [2:0]          sgn;
    logic [2:0][15:0]    mag;
    logic [2:0][31:0]    cp;    // ct * position
    logic signed [31:0]  ctkm;  // ct * km, zeroed by the torque flags
  } ctl_t;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [4:0] act_start_r;
  logic       torque_off_r, torque_off_nup_r, yaw_off_r, scalar_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_start_r      <= '0;
      torque_off_r     <= 1'b0;
      torque_off_nup_r <= 1'b0;
      yaw_off_r        <= 1'b0;
      scalar_r         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rec_pkg::CFG_ACT_START:      act_start_r      <= cfg_data[4:0];
        rec_pkg::CFG_TORQUE_OFF:     torque_off_r     <= cfg_data[0];
        rec_pkg::CFG_TORQUE_OFF_NUP: torque_off_nup_r <= cfg_data[0];
        rec_pkg::CFG_YAW_ROW_OFF:    yaw_off_r        <= cfg_data[0];
        rec_pkg::CFG_THRUST_SCALAR:  scalar_r         <= cfg_data[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: squares of the axis, ct products, column and range check
  // ---------------------------------------------------------------------------
  ctl_t             s1_ctl_r, s1_ctl_nxt;
  logic [2:0][30:0] s1_sq_r, s1_sq_nxt;

  always_comb begin
    logic signed [15:0] ax [3];
    logic signed [15:0] ps [3];
    logic signed [31:0] sq;
    logic [5:0]         sum;
    ax[0] = in_item.axis_x;
    ax[1] = in_item.axis_y;
    ax[2] = in_item.axis_z;
    ps[0] = in_item.pos_x;
    ps[1] = in_item.pos_y;
    ps[2] = in_item.pos_z;
    sum = {1'b0, act_start_r} + {2'b00, in_item.rotor_index};
    s1_ctl_nxt          = '0;
    s1_ctl_nxt.valid    = start && !busy;
    s1_ctl_nxt.column   = sum[4:0];
    s1_ctl_nxt.in_range = (sum < 6'(MAX_ACTUATORS)) &&
                          ({1'b0, in_item.rotor_index} < 5'(MAX_ROTORS));
    s1_ctl_nxt.last     = in_item.last_rotor;
    s1_ctl_nxt.ct       = in_item.ct_coeff;
    s1_ctl_nxt.ctkm     = in_item.ct_coeff * in_item.km_ratio;
    for (int l = 0; l < 3; l++) begin
      sq                = ax[l] * ax[l];
      s1_sq_nxt[l]      = sq[30:0];
      s1_ctl_nxt.sgn[l] = ax[l][15];
      s1_ctl_nxt.mag[l] = ax[l][15] ? 16'(-ax[l]) : ax[l];
      s1_ctl_nxt.cp[l]  = 32'(in_item.ct_coeff * ps[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_ctl_r <= '0;
    else        s1_ctl_r <= s1_ctl_nxt;
    s1_sq_r <= s1_sq_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: S = |a|^2, upward test, torque flags; seeds the root pipe
  // ---------------------------------------------------------------------------
  ctl_t        sq_ctl_r  [SQ_STAGES+1];
  logic [63:0] sq_x_r    [SQ_STAGES+1];
  logic [34:0] sq_rem_r  [SQ_STAGES+1];
  logic [31:0] sq_root_r [SQ_STAGES+1];
  ctl_t        s2_ctl_nxt;
  logic [31:0] s2_s;

  always_comb begin
    logic upward;
    s2_s   = 32'(s1_sq_r[0]) + 32'(s1_sq_r[1]) + 32'(s1_sq_r[2]);
    // |nx| < 0.1, |ny| < 0.1, nz < -0.5 checked on the raw axis
    upward = (38'(s1_sq_r[0]) * 38'd100 < 38'(s2_s)) &&
             (38'(s1_sq_r[1]) * 38'd100 < 38'(s2_s)) &&
             s1_ctl_r.sgn[2] &&
             ({1'b0, s1_sq_r[2], 2'b00} > 34'(s2_s));
    s2_ctl_nxt    = s1_ctl_r;
    s2_ctl_nxt.wr = s1_ctl_r.in_range && (s2_s != '0) && (s1_ctl_r.ct != '0);
    if (torque_off_r || (torque_off_nup_r && !upward)) s2_ctl_nxt.ctkm = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_ctl_r[0] <= '0;
    else        sq_ctl_r[0] <= s2_ctl_nxt;
    sq_x_r[0]    <= {s2_s, 32'd0};
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  // ---------------------------------------------------------------------------
  // Square root, floor(sqrt(S * 2^32)), bit-pair restoring method
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    logic [63:0] x_nxt;
    logic [34:0] rem_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      logic [34:0] trial;
      x_nxt    = sq_x_r[i];
      rem_nxt  = sq_rem_r[i];
      root_nxt = sq_root_r[i];
      for (int j = 0; j < SQ_STEPS; j++) begin
        rem_nxt = {rem_nxt[32:0], x_nxt[63:62]};
        x_nxt   = {x_nxt[61:0], 2'b00};
        trial   = {1'b0, root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[30:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_ctl_r[i+1] <= '0;
      else        sq_ctl_r[i+1] <= sq_ctl_r[i];
      sq_x_r[i+1]    <= x_nxt;
      sq_rem_r[i+1]  <= rem_nxt;
      sq_root_r[i+1] <= root_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Divide seed: N = |a_l| * 2^44 + root/2. Top bits of N already lie below root.
  // ---------------------------------------------------------------------------
  ctl_t        dv_ctl_r  [DV_STAGES+1];
  logic [31:0] dv_root_r [DV_STAGES+1];
  logic [31:0] dv_rem_r  [DV_STAGES+1][3];
  logic [28:0] dv_lo_r   [DV_STAGES+1][3];
  logic [28:0] dv_q_r    [DV_STAGES+1][3];

  for (genvar l = 0; l < 3; l++) begin : g_seed
    logic [59:0] num;
    assign num = (60'(sq_ctl_r[SQ_STAGES].mag[l]) << rec_pkg::NORM_FRAC) +
                 60'(sq_root_r[SQ_STAGES] >> 1);
    always_ff @(posedge clk) begin
      dv_rem_r[0][l] <= {1'b0, num[59:29]};
      dv_lo_r[0][l]  <= num[28:0];
      dv_q_r[0][l]   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_ctl_r[0] <= '0;
    else        dv_ctl_r[0] <= sq_ctl_r[SQ_STAGES];
    dv_root_r[0] <= sq_root_r[SQ_STAGES];
  end

  // ---------------------------------------------------------------------------
  // Restoring divide, three lanes sharing one root
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DV_STAGES; i++) begin : g_dv
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [31:0] rem_nxt;
      logic [28:0] lo_nxt;
      logic [28:0] q_nxt;

      always_comb begin
        logic [32:0] t;
        rem_nxt = dv_rem_r[i][l];
        lo_nxt  = dv_lo_r[i][l];
        q_nxt   = dv_q_r[i][l];
        for (int j = 0; j < DV_STEPS; j++) begin
          if (i * DV_STEPS + j < DV_BITS) begin
            t      = {rem_nxt, lo_nxt[28]};
            lo_nxt = {lo_nxt[27:0], 1'b0};
            if (t >= {1'b0, dv_root_r[i]}) begin
              rem_nxt = 32'(t - {1'b0, dv_root_r[i]});
              q_nxt   = {q_nxt[27:0], 1'b1};
            end else begin
              rem_nxt = t[31:0];
              q_nxt   = {q_nxt[27:0], 1'b0};
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        dv_rem_r[i+1][l] <= rem_nxt;
        dv_lo_r[i+1][l]  <= lo_nxt;
        dv_q_r[i+1][l]   <= q_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_ctl_r[i+1] <= '0;
      else        dv_ctl_r[i+1] <= dv_ctl_r[i];
      dv_root_r[i+1] <= dv_root_r[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Sign restore: n in Q2.28
  // ---------------------------------------------------------------------------
  ctl_t               sg_ctl_r;
  logic signed [29:0] sg_n_r [3];

  for (genvar l = 0; l < 3; l++) begin : g_sg
    logic signed [29:0] qs;
    assign qs = signed'({1'b0, dv_q_r[DV_STAGES][l]});
    always_ff @(posedge clk) begin
      sg_n_r[l] <= dv_ctl_r[DV_STAGES].sgn[l] ? -qs : qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sg_ctl_r <= '0;
    else        sg_ctl_r <= dv_ctl_r[DV_STAGES];
  end

  // ---------------------------------------------------------------------------
  // Products: ct*p (x) n terms, ct*km*n, ct*n
  // ---------------------------------------------------------------------------
  ctl_t               m1_ctl_r;
  logic signed [61:0] m1_a_r [3];
  logic signed [61:0] m1_b_r [3];
  logic signed [61:0] m1_k_r [3];
  logic signed [45:0] m1_t_r [3];

  for (genvar l = 0; l < 3; l++) begin : g_m1
    always_ff @(posedge clk) begin
      m1_a_r[l] <= $signed(sg_ctl_r.cp[(l+1)%3]) * sg_n_r[(l+2)%3];
      m1_b_r[l] <= $signed(sg_ctl_r.cp[(l+2)%3]) * sg_n_r[(l+1)%3];
      m1_k_r[l] <= sg_ctl_r.ctkm * sg_n_r[l];
      m1_t_r[l] <= sg_ctl_r.ct * sg_n_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m1_ctl_r <= '0;
    else        m1_ctl_r <= sg_ctl_r;
  end

  // ---------------------------------------------------------------------------
  // Sums: moment = 4*ct*(p x n) - ct*km*n in Q53
  // ---------------------------------------------------------------------------
  ctl_t               m2_ctl_r;
  logic signed [63:0] m2_m_r [3];
  logic signed [45:0] m2_t_r [3];

  for (genvar l = 0; l < 3; l++) begin : g_m2
    always_ff @(posedge clk) begin
      m2_m_r[l] <= ((64'(m1_a_r[l]) - 64'(m1_b_r[l])) <<< 2) - 64'(m1_k_r[l]);
      m2_t_r[l] <= m1_t_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m2_ctl_r <= '0;
    else        m2_ctl_r <= m1_ctl_r;
  end

  // ---------------------------------------------------------------------------
  // Round half away from zero to Q16, on the magnitude.
  // Magnitudes stay below 2^27, well inside the 32-bit range: no clamp.
  // ---------------------------------------------------------------------------
  ctl_t        m3_ctl_r;
  logic [26:0] m3_mr_r [3];
  logic [22:0] m3_tr_r [3];
  logic [2:0]  m3_mneg_r, m3_tneg_r;

  for (genvar l = 0; l < 3; l++) begin : g_m3
    logic [63:0] mm, mr;
    logic [45:0] tm, tr;
    always_comb begin
      mm = m2_m_r[l][63] ? 64'(-m2_m_r[l]) : 64'(m2_m_r[l]);
      mr = (mm + (64'd1 << (rec_pkg::MOMENT_SHIFT - 1))) >> rec_pkg::MOMENT_SHIFT;
      tm = m2_t_r[l][45] ? 46'(-m2_t_r[l]) : 46'(m2_t_r[l]);
      tr = (tm + (46'd1 << (rec_pkg::THRUST_SHIFT - 1))) >> rec_pkg::THRUST_SHIFT;
    end
    always_ff @(posedge clk) begin
      m3_mr_r[l]   <= mr[26:0];
      m3_tr_r[l]   <= tr[22:0];
      m3_mneg_r[l] <= m2_m_r[l][63];
      m3_tneg_r[l] <= m2_t_r[l][45];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m3_ctl_r <= '0;
    else        m3_ctl_r <= m2_ctl_r;
  end

  // ---------------------------------------------------------------------------
  // Output register: signs, overrides, unwritten columns forced to zero
  // ---------------------------------------------------------------------------
  rec_pkg::rec_out_t out_data_r, out_data_nxt;
  logic              out_strobe_r;

  always_comb begin
    logic signed [31:0] mv [3];
    logic signed [31:0] tv [3];
    for (int l = 0; l < 3; l++) begin
      mv[l] = signed'({5'd0, m3_mr_r[l]});
      tv[l] = signed'({9'd0, m3_tr_r[l]});
      if (m3_mneg_r[l]) mv[l] = -mv[l];
      if (m3_tneg_r[l]) tv[l] = -tv[l];
    end
    if (yaw_off_r) mv[2] = '0;
    if (scalar_r) begin
      tv[0] = '0;
      tv[1] = '0;
      tv[2] = -(32'(m3_ctl_r.ct) <<< 5);
    end
    out_data_nxt.column       = m3_ctl_r.column;
    out_data_nxt.in_range     = m3_ctl_r.in_range;
    out_data_nxt.write_column = m3_ctl_r.wr;
    out_data_nxt.last_out     = m3_ctl_r.last;
    out_data_nxt.moment_x     = m3_ctl_r.wr ? mv[0] : '0;
    out_data_nxt.moment_y     = m3_ctl_r.wr ? mv[1] : '0;
    out_data_nxt.moment_z     = m3_ctl_r.wr ? mv[2] : '0;
    out_data_nxt.force_x      = m3_ctl_r.wr ? tv[0] : '0;
    out_data_nxt.force_y      = m3_ctl_r.wr ? tv[1] : '0;
    out_data_nxt.force_z      = m3_ctl_r.wr ? tv[2] : '0;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= m3_ctl_r.valid;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "rotor_effectiveness_column_unit_assert.svh"

  `REC_ASSERT(a_fixed_latency, (start && !busy) |-> ##LATENCY out_strobe)
  `REC_ASSERT_ON_STROBE(a_write_needs_range, out_strobe,
                        !out_data.write_column || out_data.in_range)
  `REC_ASSERT_ON_STROBE(a_unwritten_zero, out_strobe && !out_data.write_column,
                        out_data.moment_x == '0 && out_data.force_z == '0)

endmodule
